### src/petu_pkg.sv
// petu_pkg: shared types and constants for the per-element envelope tracker.
// No dependencies; used by petu_update and per_element_envelope_tracker_unit.
`default_nettype none

package petu_pkg;

    // fixed field widths
    localparam int CFG_CNT_W  = 11;
    localparam int STEP_W     = 31;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_CNT_W-1:0] COUNT_RESET = 11'd1024;

    // register index, taken from paddr[2]
    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_ELEMENT_COUNT = 1'b0;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_opcode;

endpackage

`default_nettype wire

### src/per_element_envelope_tracker_unit.sv
// per_element_envelope_tracker_unit: running min / max / peak magnitude per element.
// Depends on petu_pkg, petu_store and petu_update.
//
//  channel | handshake                 | beat
//  --------+---------------------------+--------------------------------------------
//  input   | i_in_valid / o_in_ready   | i_opcode, i_sample_value, i_step_number
//  output  | o_out_valid / i_out_ready | o_element_index, o_running_min/max,
//          |                           | o_peak_magnitude, o_peak_step, o_step_done
//  config  | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// One beat per cycle sustained while the output is taken. A sample's store read is
// registered on the accepting edge, and the update writes the output register when
// the update stage advances. Store writes on the accepting edge are forwarded to a
// same-index read. Reset clears position, seeding and handshake state; the store is
// not cleared, as the seeding step writes every entry before it is read. A held
// output register stalls the update stage and, once that is full, drops o_in_ready.
`default_nettype none

module per_element_envelope_tracker_unit #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int SAMPLE_BITS  = 32
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    // input channel
    input  wire logic                                            i_in_valid,
    output      logic                                            o_in_ready,
    input  wire logic                                            i_opcode,
    input  wire logic signed [SAMPLE_BITS-1:0]                   i_sample_value,
    input  wire logic [petu_pkg::STEP_W-1:0]                     i_step_number,
    // output channel
    output      logic                                            o_out_valid,
    input  wire logic                                            i_out_ready,
    output      logic [((MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1)-1:0] o_element_index,
    output      logic signed [SAMPLE_BITS-1:0]                   o_running_min,
    output      logic signed [SAMPLE_BITS-1:0]                   o_running_max,
    output      logic [SAMPLE_BITS-2:0]                          o_peak_magnitude,
    output      logic [petu_pkg::STEP_W-1:0]                     o_peak_step,
    output      logic                                            o_step_done,
    // configuration
    input  wire logic                                            psel,
    input  wire logic                                            penable,
    input  wire logic                                            pwrite,
    input  wire logic [petu_pkg::APB_ADDR_W-1:0]                 paddr,
    input  wire logic [petu_pkg::APB_DATA_W-1:0]                 pwdata,
    output      logic [petu_pkg::APB_DATA_W-1:0]                 prdata,
    output      logic                                            pready
);

    localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int AW     = (IDX_W + 1 > petu_pkg::CFG_CNT_W) ? IDX_W + 1
                                                              : petu_pkg::CFG_CNT_W;
    localparam int STEP_W = petu_pkg::STEP_W;
    localparam int WORD_W = 2 * SAMPLE_BITS + (SAMPLE_BITS - 1) + STEP_W;

    // ---------------- configuration ----------------
    logic [petu_pkg::CFG_CNT_W-1:0] r_count;
    logic                           cfg_wr;
    logic                           cfg_hit;
    logic [AW-1:0]                  cnt;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2:2] == petu_pkg::REG_ELEMENT_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? petu_pkg::APB_DATA_W'(r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= petu_pkg::COUNT_RESET;
        end else if (cfg_wr) begin
            r_count <= pwdata[petu_pkg::CFG_CNT_W-1:0];
        end
    end

    // clamp the programmed count into 1..MAX_ELEMENTS
    always_comb begin
        if (r_count == '0) begin
            cnt = AW'(1);
        end else if (AW'(r_count) > AW'(MAX_ELEMENTS)) begin
            cnt = AW'(MAX_ELEMENTS);
        end else begin
            cnt = AW'(r_count);
        end
    end

    // ---------------- accept stage ----------------
    logic [IDX_W-1:0] r_position;
    logic             r_seeded;
    logic             in_fire;
    logic             smp_fire;
    logic             clr_fire;
    logic [IDX_W-1:0] idx;
    logic             last;

    // update stage
    logic                          r_s1_valid;
    logic                          r_s1_seed;
    logic                          r_s1_last;
    logic [IDX_W-1:0]              r_s1_idx;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [STEP_W-1:0]             r_s1_step;
    logic                          s1_adv;

    logic                          r_fwd;
    logic [WORD_W-1:0]             r_wb;

    logic                          r_out_valid;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;
    assign clr_fire   = in_fire && (i_opcode == petu_pkg::OP_CLEAR);
    assign smp_fire   = in_fire && (i_opcode == petu_pkg::OP_SAMPLE);

    always_comb begin
        idx  = (AW'(r_position) >= cnt) ? '0 : r_position;
        last = (AW'(idx) + AW'(1)) >= cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_seeded   <= 1'b0;
        end else if (cfg_wr || clr_fire) begin
            r_position <= '0;
            r_seeded   <= 1'b0;
        end else if (smp_fire) begin
            if (last) begin
                r_position <= '0;
                r_seeded   <= 1'b1;
            end else begin
                r_position <= idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (smp_fire) begin
            r_s1_valid <= 1'b1;
            // store write of the same element lands on this edge: forward it
            r_fwd      <= s1_adv && (r_s1_idx == idx);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_fire) begin
            r_s1_seed   <= !r_seeded;
            r_s1_last   <= last;
            r_s1_idx    <= idx;
            r_s1_sample <= i_sample_value;
            r_s1_step   <= i_step_number;
        end
    end

    // ---------------- store and update ----------------
    logic [WORD_W-1:0]             rd_word;
    logic [WORD_W-1:0]             old_word;
    logic [WORD_W-1:0]             new_word;
    logic signed [SAMPLE_BITS-1:0] new_min;
    logic signed [SAMPLE_BITS-1:0] new_max;
    logic [SAMPLE_BITS-2:0]        new_peak;
    logic [STEP_W-1:0]             new_pstep;

    petu_store #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (WORD_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (new_word),
        .i_rd_en   (smp_fire),
        .i_rd_addr (idx),
        .o_rd_data (rd_word)
    );

    assign old_word = r_fwd ? r_wb : rd_word;

    petu_update #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_update (
        .i_seed      (r_s1_seed),
        .i_sample    (r_s1_sample),
        .i_step      (r_s1_step),
        .i_old_min   (old_word[WORD_W-1 -: SAMPLE_BITS]),
        .i_old_max   (old_word[WORD_W-SAMPLE_BITS-1 -: SAMPLE_BITS]),
        .i_old_peak  (old_word[STEP_W +: SAMPLE_BITS-1]),
        .i_old_pstep (old_word[STEP_W-1:0]),
        .o_min       (new_min),
        .o_max       (new_max),
        .o_peak      (new_peak),
        .o_pstep     (new_pstep)
    );

    assign new_word = {new_min, new_max, new_peak, new_pstep};

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_wb <= new_word;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_element_index  <= r_s1_idx;
            o_running_min    <= new_min;
            o_running_max    <= new_max;
            o_peak_magnitude <= new_peak;
            o_peak_step      <= new_pstep;
            o_step_done      <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------- assertions ----------------
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !o_in_ready)
        else $error("input accepted while update stage is held");

    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW'(r_position) < cnt))
        else $error("position beyond active element count");

    a_fwd_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd) |-> $past(s1_adv))
        else $error("forwarding set without a store write");

    a_sample_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_fire |=> r_s1_valid)
        else $error("accepted sample lost before update stage");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_adv))
        else $error("result raised without an update");

endmodule

`default_nettype wire

### src/petu_store.sv
// petu_store: envelope store, one packed word per element.
// One write port and one read port with registered read data; no dependencies.
`default_nettype none

module petu_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 126
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic                                       i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/petu_update.sv
// petu_update: envelope update for one sample (min, max, peak magnitude, peak step).
// Depends on petu_pkg for the step width.
`default_nettype none

module petu_update #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                            i_seed,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic [petu_pkg::STEP_W-1:0]     i_step,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_old_min,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_old_max,
    input  wire logic [SAMPLE_BITS-2:0]          i_old_peak,
    input  wire logic [petu_pkg::STEP_W-1:0]     i_old_pstep,
    output      logic signed [SAMPLE_BITS-1:0]   o_min,
    output      logic signed [SAMPLE_BITS-1:0]   o_max,
    output      logic [SAMPLE_BITS-2:0]          o_peak,
    output      logic [petu_pkg::STEP_W-1:0]     o_pstep
);

    logic [SAMPLE_BITS-1:0] neg;
    logic [SAMPLE_BITS-2:0] mag;
    logic                   is_most_neg;

    // magnitude, most negative value saturates to all ones
    always_comb begin
        neg         = ~i_sample + SAMPLE_BITS'(1);
        is_most_neg = i_sample[SAMPLE_BITS-1] && (i_sample[SAMPLE_BITS-2:0] == '0);
        if (!i_sample[SAMPLE_BITS-1]) begin
            mag = i_sample[SAMPLE_BITS-2:0];
        end else if (is_most_neg) begin
            mag = '1;
        end else begin
            mag = neg[SAMPLE_BITS-2:0];
        end
    end

    always_comb begin
        if (i_seed) begin
            o_min   = i_sample;
            o_max   = i_sample;
            o_peak  = mag;
            o_pstep = i_step;
        end else begin
            o_min   = (i_sample < i_old_min) ? i_sample : i_old_min;
            o_max   = (i_sample > i_old_max) ? i_sample : i_old_max;
            if (mag > i_old_peak) begin
                o_peak  = mag;
                o_pstep = i_step;
            end else begin
                o_peak  = i_old_peak;
                o_pstep = i_old_pstep;
            end
        end
    end

endmodule

`default_nettype wire
